// ===== src/assert_macros.svh =====
// Assertion macros used by the converter's sequencer RTL (i2p_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock outside reset.
`define I2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define I2P_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/i2p_pkg.sv =====
// Types, character codes and decode functions for the infix-to-postfix converter.
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_marker;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic       last_in_run;
        logic       expression_end;
        logic       overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        KIND_OPERAND,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_OP,
        KIND_FLUSH
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    function automatic kind_t decode_kind(logic [7:0] c, logic e);
        kind_t k;
        if (e)
        begin
            k = KIND_FLUSH;
        end
        else
        begin
            unique case (c) inside
                CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW: k = KIND_OP;
                CH_OPEN:  k = KIND_OPEN;
                CH_CLOSE: k = KIND_CLOSE;
                default:  k = KIND_OPERAND;
            endcase
        end
        return k;
    endfunction

    function automatic logic [1:0] prec_of(logic [7:0] c);
        logic [1:0] p;
        case (c) inside
            CH_PLUS, CH_MINUS: p = 2'd1;
            CH_MUL, CH_DIV:    p = 2'd2;
            CH_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== src/i2p_stack_ram.sv =====
// Operator stack storage: one write port, one registered read port.
module i2p_stack_ram #(
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/i2p_ctrl.sv =====
// Shunting-yard sequencer: stack pointer, top-of-stack forwarding, result staging.
`include "assert_macros.svh"

module i2p_ctrl #(
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  i2p_pkg::in_word_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output i2p_pkg::out_word_t result,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [7:0]         ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [7:0]         ram_rdata
);

    i2p_pkg::state_t    state_reg, state_next;
    i2p_pkg::kind_t     kind_reg, kind_next;
    logic [7:0]         sym_reg, sym_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;
    logic               hold_valid_reg, hold_valid_next;
    i2p_pkg::out_word_t hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    i2p_pkg::out_word_t out_reg, out_next;

    logic               accept;
    logic [7:0]         top_sym;
    logic               empty;
    logic               full;
    logic               pop;
    logic               push;
    logic               gen;
    logic               fin;
    logic               need_out;
    logic               out_free;
    logic               go;
    i2p_pkg::out_word_t gen_word;
    i2p_pkg::out_word_t fin_word;
    logic [CW-1:0]      cnt_dec;

    assign top_sym  = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CW'(DEPTH));
    assign out_free = !out_valid_reg || !result_stall;
    assign accept   = item_valid && (state_reg == i2p_pkg::ST_IDLE);

    // one stack step per cycle in the work state, unless held by a stalled output
    always_comb
    begin
        pop      = 1'b0;
        push     = 1'b0;
        gen      = 1'b0;
        fin      = 1'b0;
        gen_word = '0;
        unique case (kind_reg)
            i2p_pkg::KIND_FLUSH:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    gen = (top_sym != i2p_pkg::CH_OPEN);
                end
                else
                begin
                    fin = 1'b1;
                end
                gen_word.out_symbol   = top_sym;
                gen_word.symbol_valid = 1'b1;
            end
            i2p_pkg::KIND_CLOSE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (top_sym == i2p_pkg::CH_OPEN)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        gen = 1'b1;
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
                gen_word.out_symbol   = top_sym;
                gen_word.symbol_valid = 1'b1;
            end
            i2p_pkg::KIND_OP:
            begin
                if (!empty && (i2p_pkg::prec_of(top_sym) >= i2p_pkg::prec_of(sym_reg)))
                begin
                    pop                   = 1'b1;
                    gen                   = 1'b1;
                    gen_word.out_symbol   = top_sym;
                    gen_word.symbol_valid = 1'b1;
                end
                else
                begin
                    fin               = 1'b1;
                    push              = !full;
                    gen               = full;
                    gen_word.overflow = 1'b1;
                end
            end
            i2p_pkg::KIND_OPEN:
            begin
                fin               = 1'b1;
                push              = !full;
                gen               = full;
                gen_word.overflow = 1'b1;
            end
            default:
            begin
                fin                   = 1'b1;
                gen                   = 1'b1;
                gen_word.out_symbol   = sym_reg;
                gen_word.symbol_valid = 1'b1;
            end
        endcase

        fin_word = gen ? gen_word : (hold_valid_reg ? hold_reg : '0);
        fin_word.last_in_run    = 1'b1;
        fin_word.expression_end = (kind_reg == i2p_pkg::KIND_FLUSH);

        need_out = fin ? (hold_valid_reg || gen || (kind_reg == i2p_pkg::KIND_FLUSH))
                       : (gen && hold_valid_reg);
        go = (state_reg == i2p_pkg::ST_WORK) && (!need_out || out_free);
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sym_next        = sym_reg;
        cnt_next        = cnt_reg;
        fwd_valid_next  = fwd_valid_reg;
        fwd_data_next   = fwd_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = sym_reg;

        unique case (state_reg)
            i2p_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = i2p_pkg::decode_kind(item.symbol, item.end_marker);
                    sym_next   = item.symbol;
                    state_next = i2p_pkg::ST_WORK;
                end
            end
            default:
            begin
                if (go)
                begin
                    if (pop)
                    begin
                        cnt_next       = cnt_reg - CW'(1);
                        fwd_valid_next = 1'b0;
                    end
                    if (push)
                    begin
                        ram_we         = 1'b1;
                        cnt_next       = cnt_reg + CW'(1);
                        fwd_valid_next = 1'b1;
                        fwd_data_next  = sym_reg;
                    end
                    if (fin)
                    begin
                        hold_valid_next = 1'b0;
                        state_next      = i2p_pkg::ST_IDLE;
                        if (need_out)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = fin_word;
                        end
                    end
                    else if (gen)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_next       = gen_word;
                    end
                end
            end
        endcase

        cnt_dec   = cnt_next - CW'(1);
        ram_raddr = (cnt_next == '0) ? '0 : cnt_dec[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= i2p_pkg::ST_IDLE;
            cnt_reg        <= '0;
            fwd_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fwd_valid_reg  <= fwd_valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sym_reg      <= sym_next;
        fwd_data_reg <= fwd_data_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
    end

    assign item_stall   = (state_reg != i2p_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `I2P_ASSERT(a_cnt_bound, (cnt_reg <= CW'(DEPTH)), "stack count beyond capacity")
    `I2P_ASSERT_IMPL(a_fwd_nonempty, fwd_valid_reg, !empty, "forwarded top on empty stack")
    `I2P_ASSERT_IMPL(a_idle_no_hold, (state_reg == i2p_pkg::ST_IDLE), !hold_valid_reg,
        "staged word left over after item finished")
    `I2P_ASSERT(a_flush_end,
        ((go && fin && (kind_reg == i2p_pkg::KIND_FLUSH))
            |=> (out_valid_reg && out_reg.expression_end && out_reg.last_in_run)),
        "flush did not close with an end word")

endmodule

// ===== src/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
// A word that pops nothing is decoded into kind_reg and sym_reg, and its output word is then
// registered in out_reg; a popped operator that does not end the item is staged in hold_reg.
// A new input word is taken only once the last one is finished (the '(' closing a ')' is popped
// in its finishing step); the stack RAM pops one entry per cycle unless an output stall holds it.
// Reset clears the stack count, sequencer and valid flags; stack RAM is not cleared.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  i2p_pkg::in_word_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output i2p_pkg::out_word_t result
);

    localparam int CAP = (STACK_DEPTH > i2p_pkg::MAX_RESULTS) ? i2p_pkg::MAX_RESULTS
                                                               : STACK_DEPTH;
    localparam int AW  = $clog2(CAP);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    i2p_ctrl #(
        .DEPTH (CAP)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    i2p_stack_ram #(
        .DEPTH (CAP)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== test/infix_to_postfix_converter_tb.sv =====
// Testbench for the shunting-yard infix-to-postfix converter, self-checking against a predictor.
module infix_to_postfix_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2p_pkg::*;

    localparam int STACK_CAP = (STACK_DEPTH_DEF > MAX_RESULTS) ? MAX_RESULTS : STACK_DEPTH_DEF;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    logic [7:0] op_stack [STACK_CAP];
    int         op_depth;
    out_word_t  postfix_q [$];
    out_word_t  want;
    int         error_count;
    int         items_sent;
    bit         idling_on;

    infix_to_postfix_converter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall = idling_on && ($urandom_range(99) < 37);
    end

    function automatic int unsigned rank_of(logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 1;
            CH_MUL, CH_DIV:    return 2;
            CH_POW:            return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic bit is_operator(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV || c == CH_POW;
    endfunction

    function automatic bit is_special(logic [7:0] c);
        return is_operator(c) || c == CH_OPEN || c == CH_CLOSE;
    endfunction

    function automatic out_word_t make_word(logic [7:0] sym, logic vld, logic ovf);
        out_word_t w;
        w.out_symbol     = sym;
        w.symbol_valid   = vld;
        w.last_in_run    = 1'b0;
        w.expression_end = 1'b0;
        w.overflow       = ovf;
        return w;
    endfunction

    // one input word -> expected output words, appended to postfix_q
    function automatic void predict_postfix(logic [7:0] sym, logic endm);
        out_word_t  run [MAX_RESULTS + 1];
        int         n;
        logic [7:0] popped;
        n = 0;
        if (endm)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                popped = op_stack[op_depth];
                if (popped != CH_OPEN)
                begin
                    run[n] = make_word(popped, 1'b1, 1'b0);
                    n++;
                end
            end
            if (n == 0)
            begin
                run[0] = make_word(8'h00, 1'b0, 1'b0);
                n = 1;
            end
            run[n - 1].expression_end = 1'b1;
        end
        else if (sym == CH_OPEN)
        begin
            if (op_depth >= STACK_CAP)
            begin
                run[0] = make_word(8'h00, 1'b0, 1'b1);
                n = 1;
            end
            else
            begin
                op_stack[op_depth] = sym;
                op_depth++;
            end
        end
        else if (sym == CH_CLOSE)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                popped = op_stack[op_depth];
                if (popped == CH_OPEN)
                    break;
                run[n] = make_word(popped, 1'b1, 1'b0);
                n++;
            end
        end
        else if (is_operator(sym))
        begin
            while (op_depth > 0 && rank_of(sym) <= rank_of(op_stack[op_depth - 1]))
            begin
                op_depth--;
                run[n] = make_word(op_stack[op_depth], 1'b1, 1'b0);
                n++;
            end
            if (op_depth >= STACK_CAP)
            begin
                run[n] = make_word(8'h00, 1'b0, 1'b1);
                n++;
            end
            else
            begin
                op_stack[op_depth] = sym;
                op_depth++;
            end
        end
        else
        begin
            run[0] = make_word(sym, 1'b1, 1'b0);
            n = 1;
        end
        if (n > 0)
            run[n - 1].last_in_run = 1'b1;
        for (int i = 0; i < n; i++)
            postfix_q.push_back(run[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (postfix_q.size() == 0)
            begin
                $error("unexpected output word %h", result);
                error_count++;
            end
            else
            begin
                want = postfix_q.pop_front();
                check_field("out_symbol", want.out_symbol, result.out_symbol);
                check_field("symbol_valid", want.symbol_valid, result.symbol_valid);
                check_field("last_in_run", want.last_in_run, result.last_in_run);
                check_field("expression_end", want.expression_end, result.expression_end);
                check_field("overflow", want.overflow, result.overflow);
            end
        end
    end

    task automatic send_word(input logic [7:0] sym, input logic endm);
        while (idling_on && $urandom_range(99) < 37)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid      = 1'b1;
        item.symbol     = sym;
        item.end_marker = endm;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_postfix(sym, endm);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic wait_for_results();
        item_valid = 1'b0;
        while (postfix_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
            return 8'h61 + 8'($urandom_range(25));
        do
            c = 8'($urandom_range(255));
        while (is_special(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    // well-formed expression, sometimes left with open brackets at the end marker
    task automatic send_expression(input int max_nest);
        int nest;
        int terms;
        nest  = 0;
        terms = $urandom_range(1, 8);
        for (int t = 0; t < terms; t++)
        begin
            while (nest < max_nest && $urandom_range(3) == 0)
            begin
                send_word(CH_OPEN, 1'b0);
                nest++;
            end
            send_word(pick_operand(), 1'b0);
            while (nest > 0 && $urandom_range(2) == 0)
            begin
                send_word(CH_CLOSE, 1'b0);
                nest--;
            end
            if (t < terms - 1)
                send_word(pick_operator(), 1'b0);
        end
        if ($urandom_range(9) != 0)
            repeat (nest) send_word(CH_CLOSE, 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic test_operands();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h20, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_precedence();
        send_text("a-b*c^d^e/f");
        send_word(8'h00, 1'b1);
    endtask

    // stray close on empty stack, matched pair, unmatched close, open left at end
    task automatic test_brackets();
        send_text(")a*(b-c))+(");
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_CAP) send_word(CH_OPEN, 1'b0);
        send_word(CH_OPEN, 1'b0);
        send_word(CH_PLUS, 1'b0);
        send_word(CH_CLOSE, 1'b0);
        send_word(CH_POW, 1'b0);
        send_word(CH_MUL, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        repeat (8) send_expression(3);
        idling_on = 1'b1;
    endtask

    task automatic test_random_expressions();
        while (items_sent < 350)
        begin
            if ($urandom_range(7) == 0)
                send_expression(STACK_CAP);
            else
                send_expression($urandom_range(0, 4));
        end
    endtask

    task automatic test_noise();
        int r;
        repeat (80)
        begin
            r = $urandom_range(9);
            if (r == 0)
                send_word(8'($urandom_range(255)), 1'b1);
            else if (r < 6)
                send_word($urandom_range(1) ? pick_operator()
                          : ($urandom_range(1) ? CH_OPEN : CH_CLOSE), 1'b0);
            else
                send_word(8'($urandom_range(255)), 1'b0);
        end
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        idling_on    = 1'b1;
        op_depth     = 0;
        error_count  = 0;
        items_sent   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_operands();
        test_precedence();
        test_brackets();
        wait_for_results();
        test_stack_overflow();
        test_back_to_back();
        test_random_expressions();
        test_noise();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("infix_to_postfix_converter_tb: done, clean");
        else
            $display("infix_to_postfix_converter_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("infix_to_postfix_converter_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/i2p_pkg.sv
src/i2p_stack_ram.sv
src/i2p_ctrl.sv
src/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
